// ----- src/byte_pattern_matcher_macros.svh -----
// ----------------------------------------------------------------------------
// Byte pattern matcher assertion macros
// Shorthand for clocked, reset-qualified checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_PATTERN_MATCHER_MACROS_SVH
`define BYTE_PATTERN_MATCHER_MACROS_SVH

// same-cycle implication
`define BPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte pattern matcher check failed");

// next-cycle implication
`define BPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte pattern matcher check failed");

`endif

// ----- src/bpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte pattern matcher package
// Shared constants, codes, beat types and byte compare helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bpm_pkg;

    localparam int BPM_MAX_PATTERN = 32;
    localparam int BPM_QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_BUFFER = 2'd2;

    localparam logic [1:0] MODE_EXACT    = 2'd0;
    localparam logic [1:0] MODE_NOCASE   = 2'd1;
    localparam logic [1:0] MODE_RELATIVE = 2'd2;

    localparam logic [1:0] REG_MATCH_MODE  = 2'd0;
    localparam logic [1:0] REG_WILD_ENABLE = 2'd1;
    localparam logic [1:0] REG_WILD_BYTE   = 2'd2;

    localparam logic [31:0] SEEN_MAX = 32'hffff_ffff;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CLEAR,
        KIND_APPEND,
        KIND_BUFFER
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic        match;
        logic        first;
        logic [31:0] offset;
    } result_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       wild_en;
        logic [7:0] wild_byte;
    } cfg_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5a);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return is_upper(c) ? c + 8'd32 : c;
    endfunction

    function automatic logic byte_eq(input logic [7:0] p, input logic [7:0] b,
                                     input logic nocase);
        if (nocase && is_letter(p)) begin
            return to_lower(b) == to_lower(p);
        end
        return b == p;
    endfunction

endpackage

`default_nettype wire

// ----- src/bpm_fifo.sv -----
// ----------------------------------------------------------------------------
// Byte pattern matcher beat queue
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_fire;
    logic             rd_fire;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign wr_fire = wr_en && !full;
    assign rd_fire = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_fire && !rd_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_fire && rd_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/bpm_front.sv -----
// ----------------------------------------------------------------------------
// Byte pattern matcher front end
// Accepts input beats, decodes the opcode and queues commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_front
    import bpm_pkg::*;
#(
    parameter int DEPTH = BPM_QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] opcode,
    input  wire logic [7:0] byte_value,
    output cmd_t            cmd,
    output logic            cmd_valid,
    input  wire logic       cmd_take
);

    cmd_t                   cmd_in;
    logic                   cmd_empty;
    logic [$bits(cmd_t)-1:0] cmd_bits;

    always_comb
    begin
        cmd_in.data = byte_value;
        unique case (opcode)
            OP_CLEAR:  cmd_in.kind = KIND_CLEAR;
            OP_APPEND: cmd_in.kind = KIND_APPEND;
            OP_BUFFER: cmd_in.kind = KIND_BUFFER;
            default:   cmd_in.kind = KIND_NONE;
        endcase
    end

    bpm_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_take),
        .rd_data (cmd_bits),
        .empty   (cmd_empty)
    );

    assign cmd       = cmd_t'(cmd_bits);
    assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// ----- src/bpm_back.sv -----
// ----------------------------------------------------------------------------
// Byte pattern matcher back end
// Updates pattern, window and counters, then compares all window positions.
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_back
    import bpm_pkg::*;
#(
    parameter int MAX_PATTERN = BPM_MAX_PATTERN
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire cmd_t cmd,
    input  wire logic cmd_valid,
    output logic      cmd_take,
    output result_t   res,
    output logic      res_write,
    input  wire logic res_full
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int POS_W = CNT_W + 1;

    logic [7:0]       pat_reg [MAX_PATTERN];
    logic [7:0]       win_reg [MAX_PATTERN];
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      seen_reg;
    logic             found_reg;
    logic             s2_valid_reg;
    logic             s2_buffer_reg;

    logic                   go;
    logic [MAX_PATTERN-1:0] eq_ok;
    logic [MAX_PATTERN-1:0] rel_ok;
    logic [MAX_PATTERN-1:0] in_win;
    logic [MAX_PATTERN-1:0] wild;
    logic [32:0]            span;
    logic                   win_ok;
    logic                   hit;

    assign go        = !res_full;
    assign cmd_take  = go && cmd_valid;
    assign res_write = go && s2_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd.kind == KIND_APPEND && count_reg != CNT_W'(MAX_PATTERN))
        begin
            for (int k = 0; k < MAX_PATTERN - 1; k++)
            begin
                pat_reg[k] <= pat_reg[k + 1];
            end
            pat_reg[MAX_PATTERN - 1] <= cmd.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= '0;
            end
            count_reg     <= '0;
            seen_reg      <= '0;
            found_reg     <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_buffer_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                s2_valid_reg  <= cmd_take;
                s2_buffer_reg <= cmd.kind == KIND_BUFFER;
            end
            if (res_write && res.match)
            begin
                found_reg <= 1'b1;
            end
            if (cmd_take)
            begin
                unique case (cmd.kind)
                    KIND_CLEAR:
                    begin
                        for (int k = 0; k < MAX_PATTERN; k++)
                        begin
                            win_reg[k] <= '0;
                        end
                        count_reg <= '0;
                        seen_reg  <= '0;
                        found_reg <= 1'b0;
                    end
                    KIND_APPEND:
                    begin
                        if (count_reg != CNT_W'(MAX_PATTERN))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    KIND_BUFFER:
                    begin
                        for (int k = 0; k < MAX_PATTERN - 1; k++)
                        begin
                            win_reg[k] <= win_reg[k + 1];
                        end
                        win_reg[MAX_PATTERN - 1] <= cmd.data;
                        if (seen_reg != SEEN_MAX)
                        begin
                            seen_reg <= seen_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // pattern and window are right-aligned: position k pairs pattern and window bytes
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            in_win[k] = (POS_W'(k) + POS_W'(count_reg)) >= POS_W'(MAX_PATTERN);
            wild[k]   = cfg.wild_en && (pat_reg[k] == cfg.wild_byte);
            eq_ok[k]  = !in_win[k] || wild[k]
                        || byte_eq(pat_reg[k], win_reg[k], cfg.mode == MODE_NOCASE);
        end
        for (int k = 0; k < MAX_PATTERN - 1; k++)
        begin
            rel_ok[k] = !in_win[k] || wild[k]
                        || (({1'b0, win_reg[k]} - {1'b0, win_reg[k + 1]})
                            == ({1'b0, pat_reg[k]} - {1'b0, pat_reg[k + 1]}));
        end
        rel_ok[MAX_PATTERN - 1] = 1'b1;

        span = {1'b0, seen_reg} - 33'(count_reg);
        if (cfg.mode == MODE_RELATIVE)
        begin
            win_ok = (count_reg >= CNT_W'(2)) && (&rel_ok);
        end
        else
        begin
            win_ok = &eq_ok;
        end

        if (!s2_buffer_reg)
        begin
            hit = 1'b0;
        end
        else if (count_reg == '0)
        begin
            hit = cfg.mode != MODE_RELATIVE;
        end
        else
        begin
            hit = !span[32] && win_ok;
        end

        res.match  = hit;
        res.first  = hit && !found_reg;
        res.offset = (hit && count_reg != '0) ? span[31:0] : 32'd0;
    end

endmodule

`default_nettype wire

// ----- src/byte_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// Byte pattern matcher
// Streaming search of a buffer for a loaded byte pattern, with exact,
// case-insensitive and relative-difference compare and a single-byte wildcard.
// ----------------------------------------------------------------------------
// Every accepted beat yields exactly one result beat, in order. The block
// sustains one beat per clock while the result queue has room: the window of
// the last MAX_PATTERN buffer bytes is compared against the pattern at all
// positions at once, and that compare sets the rate. Two-entry queues sit on
// both sides; full rises only when the input queue holds two commands because
// the result side is stalled. Non-buffer beats return match 0,
// first_match_res 0 and match_offset 0. Configuration is written directly
// through cfg_write, cfg_index and cfg_data; the user must do so only while
// the block is idle, which the block itself does not enforce.
`default_nettype none

module byte_pattern_matcher
    import bpm_pkg::*;
#(
    parameter int MAX_PATTERN = BPM_MAX_PATTERN,
    parameter int QUEUE_DEPTH = BPM_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  byte_value,
    output logic             empty,
    input  wire logic        pop,
    output logic             match,
    output logic             first_match_res,
    output logic [31:0]      match_offset
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    logic    cmd_valid;
    logic    cmd_take;
    result_t res;
    logic    res_write;
    logic    res_full;
    result_t res_out;
    logic [$bits(result_t)-1:0] res_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MATCH_MODE:  cfg_reg.mode      <= cfg_data[1:0];
                REG_WILD_ENABLE: cfg_reg.wild_en   <= cfg_data[0];
                REG_WILD_BYTE:   cfg_reg.wild_byte <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    bpm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .byte_value (byte_value),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_take   (cmd_take)
    );

    bpm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .res       (res),
        .res_write (res_write),
        .res_full  (res_full)
    );

    bpm_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_write),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign res_out         = result_t'(res_bits);
    assign match           = res_out.match;
    assign first_match_res = res_out.first;
    assign match_offset    = res_out.offset;

endmodule

`default_nettype wire

// ----- src/bpm_checker.sv -----
// ----------------------------------------------------------------------------
// Byte pattern matcher port checker
// Watches the result port of the top level and flags inconsistent beats.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_pattern_matcher_macros.svh"

module bpm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        match,
    input wire logic        first_match_res,
    input wire logic [31:0] match_offset
);

    `BPM_ASSERT_NOW(first_needs_match, !empty && first_match_res, match)
    `BPM_ASSERT_NOW(miss_has_zero_offset, !empty && !match, match_offset == 32'd0)
    `BPM_ASSERT_NEXT(stalled_beat_holds, !empty && !pop, !empty && $stable(match) && $stable(first_match_res) && $stable(match_offset))

endmodule

bind byte_pattern_matcher bpm_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .pop             (pop),
    .match           (match),
    .first_match_res (first_match_res),
    .match_offset    (match_offset)
);

`default_nettype wire

// ----- test/byte_pattern_matcher_test.sv -----
// ----------------------------------------------------------------------------
// Byte pattern matcher testbench
// Drives command beats (clear, pattern append, buffer byte, unused opcode)
// through the input queue under random gaps and back-pressure. A model of
// the pattern store, shifting window and match flags in the bench predicts
// one result beat per command. Each popped result is compared field by field
// with the oldest prediction. Phases cover every match mode and several
// wildcard settings.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_pattern_matcher_test;
    import bpm_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 1000;
    localparam int CHOKE_CYCLES = 80;
    localparam int RAND_PHASES  = 14;
    localparam int PHASE_ITEMS  = 62;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] val;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_MATCH_MODE;
    logic [7:0]  cfg_data = 8'd0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  opcode = OP_CLEAR;
    logic [7:0]  byte_value = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic        match;
    logic        first_match_res;
    logic [31:0] match_offset;

    beat_t   cmd_queue[$];
    result_t due_matches[$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      tx_wait = 0;
    int      rx_wait = 0;
    logic    tx_calm = 1'b0;
    logic    rx_calm = 1'b0;
    logic    choke_req = 1'b0;
    logic    choke_done = 1'b0;

    logic [7:0]  pat_mem [BPM_MAX_PATTERN];
    logic [7:0]  win_mem [BPM_MAX_PATTERN];
    logic [5:0]  pat_len = 6'd0;
    logic [31:0] seen_cnt = 32'd0;
    logic        found_any = 1'b0;
    logic [1:0]  cur_mode = MODE_EXACT;
    logic        wild_on = 1'b0;
    logic [7:0]  wild_val = 8'd0;

    byte_pattern_matcher dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .opcode          (opcode),
        .byte_value      (byte_value),
        .empty           (empty),
        .pop             (pop),
        .match           (match),
        .first_match_res (first_match_res),
        .match_offset    (match_offset)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] fold(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return fold(c) >= 8'h61 && fold(c) <= 8'h7a;
    endfunction

    function automatic logic is_wild(logic [7:0] p);
        return wild_on && p == wild_val;
    endfunction

    function automatic logic window_hit();
        int base, b0, b1, p0, p1;
        logic [7:0] p, w;
        base = BPM_MAX_PATTERN - int'(pat_len);
        if (cur_mode == MODE_RELATIVE)
        begin
            if (pat_len < 2)
                return 1'b0;
            for (int i = 0; i + 1 < int'(pat_len); i++)
            begin
                if (is_wild(pat_mem[i]))
                    continue;
                b0 = win_mem[base + i];
                b1 = win_mem[base + i + 1];
                p0 = pat_mem[i];
                p1 = pat_mem[i + 1];
                if (b0 - b1 != p0 - p1)
                    return 1'b0;
            end
            return 1'b1;
        end
        for (int i = 0; i < int'(pat_len); i++)
        begin
            p = pat_mem[i];
            w = win_mem[base + i];
            if (is_wild(p))
                continue;
            if (cur_mode == MODE_NOCASE && is_alpha(p))
            begin
                if (fold(w) != fold(p))
                    return 1'b0;
            end
            else if (w != p)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void search_step(logic [1:0] op, logic [7:0] val);
        result_t r;
        r = '0;
        case (op)
            OP_CLEAR:
            begin
                pat_len = 6'd0;
                for (int k = 0; k < BPM_MAX_PATTERN; k++)
                    win_mem[k] = 8'd0;
                seen_cnt = 32'd0;
                found_any = 1'b0;
            end
            OP_APPEND:
            begin
                if (pat_len < BPM_MAX_PATTERN)
                begin
                    pat_mem[pat_len] = val;
                    pat_len = pat_len + 6'd1;
                end
            end
            OP_BUFFER:
            begin
                for (int k = 0; k < BPM_MAX_PATTERN - 1; k++)
                    win_mem[k] = win_mem[k + 1];
                win_mem[BPM_MAX_PATTERN - 1] = val;
                if (seen_cnt != SEEN_MAX)
                    seen_cnt = seen_cnt + 32'd1;
                if (pat_len == 0)
                    r.match = (cur_mode != MODE_RELATIVE);
                else if (seen_cnt >= pat_len && window_hit())
                begin
                    r.match = 1'b1;
                    r.offset = seen_cnt - pat_len;
                end
                if (r.match)
                begin
                    r.first = !found_any;
                    found_any = 1'b1;
                end
            end
            default: ;
        endcase
        due_matches.push_back(r);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return wild_val;
        if (r < 45)
            return 8'h41 + 8'($urandom_range(0, 3)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        if (r < 55)
            return $urandom_range(0, 1) ? 8'h00 : 8'hff;
        return 8'($urandom);
    endfunction

    function automatic void add_beat(logic [1:0] op, logic [7:0] val);
        beat_t b;
        b.op = op;
        b.val = val;
        cmd_queue.push_back(b);
    endfunction

    // driver: offer queued beats, predict on accept
    always @(posedge clk)
    begin : drive
        beat_t nxt;
        if (rst_n)
        begin
            if (push && !full)
            begin
                search_step(opcode, byte_value);
                if (!tx_calm)
                    tx_wait = pick_gap();
            end
            if (!push || !full)
            begin
                if (tx_wait > 0)
                begin
                    push <= 1'b0;
                    tx_wait--;
                end
                else if (cmd_queue.size() > 0)
                begin
                    nxt = cmd_queue.pop_front();
                    push <= 1'b1;
                    opcode <= nxt.op;
                    byte_value <= nxt.val;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: compare popped beats, pace pop
    always @(posedge clk)
    begin : watch
        result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (due_matches.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected (match %0d offset %0d)",
                             $time, match, match_offset);
                    errors++;
                end
                else
                begin
                    want = due_matches.pop_front();
                    if (match !== want.match)
                    begin
                        $display("%0t: match expected %0d, got %0d", $time, want.match, match);
                        errors++;
                    end
                    if (first_match_res !== want.first)
                    begin
                        $display("%0t: first_match_res expected %0d, got %0d",
                                 $time, want.first, first_match_res);
                        errors++;
                    end
                    if (match_offset !== want.offset)
                    begin
                        $display("%0t: match_offset expected %0d, got %0d",
                                 $time, want.offset, match_offset);
                        errors++;
                    end
                end
                if (rx_wait == 0 && !rx_calm)
                    rx_wait = pick_gap();
            end
            if (choke_req && !choke_done)
            begin
                choke_done = 1'b1;
                rx_wait = CHOKE_CYCLES;
            end
            if (rx_wait > 0)
            begin
                pop <= 1'b0;
                rx_wait--;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_MATCH_MODE:  cur_mode = val[1:0];
            REG_WILD_ENABLE: wild_on = val[0];
            REG_WILD_BYTE:   wild_val = val;
            default: ;
        endcase
    endtask

    task automatic apply_setup(logic [1:0] m, logic en, logic [7:0] wb);
        write_reg(REG_MATCH_MODE, {6'd0, m});
        write_reg(REG_WILD_ENABLE, {7'd0, en});
        write_reg(REG_WILD_BYTE, wb);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // hold until every beat is in and every result is out
    task automatic drain();
        while (cmd_queue.size() != 0 || push || due_matches.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic plan_search(output int used);
        logic [7:0] pat[$];
        logic [7:0] v;
        int len, n, r, lo, hi, k, cl, miss;
        used = 0;
        if ($urandom_range(0, 9) != 0)
        begin
            add_beat(OP_CLEAR, 8'($urandom));
            used++;
        end
        r = $urandom_range(0, 99);
        len = (r < 85) ? $urandom_range(0, 5) :
              (r < 95) ? $urandom_range(6, 16) : $urandom_range(30, 34);
        for (int i = 0; i < len; i++)
        begin
            v = pick_byte();
            pat.push_back(v);
            add_beat(OP_APPEND, v);
            used++;
        end
        cl = (len > BPM_MAX_PATTERN) ? BPM_MAX_PATTERN : len;
        n = len + $urandom_range(2, 20);
        while (n > 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                add_beat(OP_UNUSED, 8'($urandom));
            else if (r < 7)
                add_beat(OP_APPEND, pick_byte());
            else if (r < 35 && cl > 0)
            begin
                lo = 255;
                hi = 0;
                for (int i = 0; i < cl; i++)
                begin
                    if (pat[i] < lo)
                        lo = pat[i];
                    if (pat[i] > hi)
                        hi = pat[i];
                end
                k = (cur_mode == MODE_RELATIVE) ? int'($urandom_range(0, 255 - hi + lo)) - lo : 0;
                miss = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, cl - 1)) : -1;
                for (int i = 0; i < cl; i++)
                begin
                    v = 8'(int'(pat[i]) + k);
                    if (cur_mode != MODE_RELATIVE)
                    begin
                        if (is_wild(pat[i]) && $urandom_range(0, 1))
                            v = 8'($urandom);
                        else if (cur_mode == MODE_NOCASE && is_alpha(v) && $urandom_range(0, 1))
                            v = v ^ 8'h20;
                    end
                    if (i == miss)
                        v = 8'($urandom);
                    add_beat(OP_BUFFER, v);
                end
                used += cl - 1;
                n -= cl - 1;
            end
            else
                add_beat(OP_BUFFER, pick_byte());
            used++;
            n--;
        end
    endtask

    initial
    begin
        logic [1:0] mode_seq [6];
        logic       en_seq [6];
        logic [7:0] wb_seq [6];
        logic [1:0] mode_pick [4];
        int used, total;
        mode_seq = '{MODE_EXACT, MODE_NOCASE, MODE_RELATIVE, MODE_UNUSED,
                     MODE_RELATIVE, MODE_NOCASE};
        en_seq = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        wb_seq = '{8'h00, 8'h61, 8'h10, 8'h41, 8'h00, 8'hff};
        mode_pick = '{MODE_EXACT, MODE_NOCASE, MODE_RELATIVE, MODE_UNUSED};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        apply_setup(MODE_EXACT, 1'b0, 8'h00);
        add_beat(OP_BUFFER, 8'h41);
        add_beat(OP_UNUSED, 8'hff);
        add_beat(OP_CLEAR, 8'hff);
        add_beat(OP_APPEND, 8'h00);
        add_beat(OP_APPEND, 8'hff);
        add_beat(OP_APPEND, 8'h41);
        add_beat(OP_BUFFER, 8'h00);
        add_beat(OP_BUFFER, 8'hff);
        add_beat(OP_BUFFER, 8'h41);
        add_beat(OP_BUFFER, 8'h00);
        add_beat(OP_BUFFER, 8'hff);
        add_beat(OP_BUFFER, 8'h41);
        drain();

        apply_setup(MODE_NOCASE, 1'b1, 8'h2a);
        add_beat(OP_CLEAR, 8'h00);
        add_beat(OP_APPEND, 8'h61);
        add_beat(OP_APPEND, 8'h2a);
        add_beat(OP_APPEND, 8'h5a);
        add_beat(OP_APPEND, 8'h5b);
        add_beat(OP_BUFFER, 8'h41);
        add_beat(OP_BUFFER, 8'h00);
        add_beat(OP_BUFFER, 8'h7a);
        add_beat(OP_BUFFER, 8'h5b);
        drain();

        apply_setup(MODE_RELATIVE, 1'b1, 8'hff);
        add_beat(OP_CLEAR, 8'h00);
        add_beat(OP_APPEND, 8'hff);
        add_beat(OP_BUFFER, 8'h05);
        add_beat(OP_APPEND, 8'h10);
        add_beat(OP_APPEND, 8'h30);
        add_beat(OP_BUFFER, 8'h77);
        add_beat(OP_BUFFER, 8'h20);
        add_beat(OP_BUFFER, 8'h40);
        add_beat(OP_CLEAR, 8'h00);
        add_beat(OP_BUFFER, 8'h00);
        drain();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p < 6)
                apply_setup(mode_seq[p], en_seq[p], wb_seq[p]);
            else
                apply_setup(($urandom_range(0, 9) == 0) ? mode_pick[3] :
                            mode_pick[$urandom_range(0, 2)],
                            1'($urandom_range(0, 1)),
                            $urandom_range(0, 1) ? 8'h41 + 8'($urandom_range(0, 3)) : 8'($urandom));
            tx_calm = (p == 2 || p == 6);
            rx_calm = (p == 3);
            if (p == 6)
                choke_req = 1'b1;
            total = 0;
            while (total < PHASE_ITEMS)
            begin
                plan_search(used);
                total += used;
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && due_matches.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
